/* design/sipd_pkg.sv */
// Shared types, register indexes, operation codes and shift helper for the
// shift-and-add IIR low-pass filter with peak detection. No dependencies.
`default_nettype none

package sipd_pkg;

  // Operation codes carried in the input beat.
  localparam logic [1:0] OP_FILTER_NARROW = 2'd0;
  localparam logic [1:0] OP_FILTER_WIDE   = 2'd1;
  localparam logic [1:0] OP_INIT          = 2'd2;

  // Configuration register indexes and widths.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 5;
  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_SHIFT    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_SHIFT = 1'b1;
  localparam logic [CFG_DATA_W-1:0]  INPUT_SHIFT_RESET    = 5'd4;
  localparam logic [CFG_DATA_W-1:0]  FEEDBACK_SHIFT_RESET = 5'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] sample;
    logic signed [31:0] sample_wide;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] filtered;
    logic signed [31:0] filtered_wide;
    logic               pos_peak;
    logic               neg_peak;
    logic signed [15:0] peak_value;
  } out_item_t;

  // Input history x0..x2 and output history y0..y2, newest first.
  typedef struct packed {
    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] y0;
    logic [31:0] y1;
    logic [31:0] y2;
  } hist_t;

  // Arithmetic right shift of a 32-bit word; a 5-bit amount never exceeds 31.
  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] s);
    return 32'($signed(x) >>> s);
  endfunction

endpackage

`default_nettype wire

/* design/sipd_step.sv */
// One filter step: next history and the result beat for one input item.
// Pure combinational logic; depends on sipd_pkg.
`default_nettype none

module sipd_step #(
  parameter int FRAC_BITS = 16
) (
  input  wire sipd_pkg::in_item_t  item,
  input  wire sipd_pkg::hist_t     hist,
  input  wire logic [4:0]          input_shift,
  input  wire logic [4:0]          feedback_shift,
  output sipd_pkg::hist_t          hist_next,
  output sipd_pkg::out_item_t      result
);

  logic [31:0] narrow_ext;
  logic [31:0] narrow_widened;
  logic [31:0] x_new;
  logic [4:0]  shift_mid;
  logic [4:0]  shift_fb;
  logic [31:0] y_new;
  logic        pos;
  logic        neg;
  logic [31:0] filtered_shifted;
  logic [31:0] peak_shifted;

  assign narrow_ext     = {{16{item.sample[15]}}, item.sample};
  assign narrow_widened = narrow_ext << FRAC_BITS;

  assign x_new = (item.operation == sipd_pkg::OP_FILTER_WIDE) ? item.sample_wide
                                                               : narrow_widened;

  // The middle tap and the last feedback term use smaller shifts, floored at zero.
  assign shift_mid = (input_shift == 5'd0) ? 5'd0 : input_shift - 5'd1;
  assign shift_fb  = (input_shift < 5'd2)  ? 5'd0 : input_shift - 5'd2;

  // Here y1 is the old y0 and y2 the old y1; x1 and x2 likewise.
  assign y_new = (hist.y0 - hist.y1) + hist.y0
               - sipd_pkg::asr32(hist.y0, feedback_shift)
               + sipd_pkg::asr32(hist.y1, feedback_shift)
               + sipd_pkg::asr32(x_new, input_shift)
               + sipd_pkg::asr32(hist.x0, shift_mid)
               + sipd_pkg::asr32(hist.x1, input_shift)
               - sipd_pkg::asr32(hist.y1, shift_fb);

  always_comb begin
    case (item.operation)
      sipd_pkg::OP_FILTER_NARROW, sipd_pkg::OP_FILTER_WIDE: begin
        hist_next.x0 = x_new;
        hist_next.x1 = hist.x0;
        hist_next.x2 = hist.x1;
        hist_next.y0 = y_new;
        hist_next.y1 = hist.y0;
        hist_next.y2 = hist.y1;
      end
      sipd_pkg::OP_INIT: begin
        hist_next.x0 = narrow_widened;
        hist_next.x1 = narrow_widened;
        hist_next.x2 = narrow_widened;
        hist_next.y0 = narrow_widened;
        hist_next.y1 = narrow_widened;
        hist_next.y2 = narrow_widened;
      end
      default: begin
        hist_next = hist;
      end
    endcase
  end

  assign pos = ($signed(hist_next.y0) <  $signed(hist_next.y1)) &&
               ($signed(hist_next.y1) >= $signed(hist_next.y2));
  assign neg = ($signed(hist_next.y0) >  $signed(hist_next.y1)) &&
               ($signed(hist_next.y1) <= $signed(hist_next.y2));

  assign filtered_shifted = sipd_pkg::asr32(hist_next.y0, 5'(FRAC_BITS));
  assign peak_shifted     = sipd_pkg::asr32(hist_next.y1, 5'(FRAC_BITS));

  always_comb begin
    result.filtered      = filtered_shifted[15:0];
    result.filtered_wide = hist_next.y0;
    result.pos_peak      = pos;
    result.neg_peak      = neg;
    result.peak_value    = (pos || neg) ? peak_shifted[15:0] : 16'sd0;
  end

endmodule

`default_nettype wire

/* design/shift_iir_lowpass_peak_detect.sv */
// Top level of the shift-and-add second-order IIR low-pass filter with peak
// detection. Depends on sipd_pkg and sipd_step.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+----------------------------
//   in      | to block  | in_valid / in_ready   | in_data  (sipd_pkg::in_item_t)
//   out     | from block| out_valid / out_ready | out_data (sipd_pkg::out_item_t)
//   cfg     | to block  | cfg_we (no wait)      | cfg_index, cfg_data
//
// Every beat passes from acceptance through the input register and then through
// the filter step into the result register. A new beat can be accepted every
// cycle while the output is not stalled; the recursive history update is a
// single pass of shifts and one nine-term add, which sets the clock-to-clock path.
// A stall on the output holds the result register and the input register, and
// the input side keeps accepting as long as the input register can drain.
// Synchronous reset clears both histories to zero and loads the shift
// registers with their defaults (input shift 4, feedback shift 2).
`default_nettype none

module shift_iir_lowpass_peak_detect #(
  parameter int FRACTION_EXTRA_BITS = 16
) (
  input  wire                                        clk,
  input  wire                                        rst,
  input  wire                                        in_valid,
  output logic                                       in_ready,
  input  wire sipd_pkg::in_item_t                    in_data,
  output logic                                       out_valid,
  input  wire                                        out_ready,
  output sipd_pkg::out_item_t                        out_data,
  input  wire                                        cfg_we,
  input  wire logic [sipd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [sipd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // Configuration registers.
  logic [4:0] input_shift;
  logic [4:0] feedback_shift;

  // Input register stage.
  logic               s1_valid;
  sipd_pkg::in_item_t s1_item;

  // Filter state and step results.
  sipd_pkg::hist_t     hist;
  sipd_pkg::hist_t     hist_next;
  sipd_pkg::out_item_t result;

  // The beat in the input register moves on when the result register is empty
  // or its current beat is being taken this cycle.
  logic advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Configuration writes must arrive only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_shift    <= sipd_pkg::INPUT_SHIFT_RESET;
      feedback_shift <= sipd_pkg::FEEDBACK_SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sipd_pkg::REG_INPUT_SHIFT:    input_shift    <= cfg_data;
        sipd_pkg::REG_FEEDBACK_SHIFT: feedback_shift <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: loads on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  sipd_step #(
    .FRAC_BITS(FRACTION_EXTRA_BITS)
  ) u_step (
    .item          (s1_item),
    .hist          (hist),
    .input_shift   (input_shift),
    .feedback_shift(feedback_shift),
    .hist_next     (hist_next),
    .result        (result)
  );

  // The history commits at the same edge that the result is registered, so the
  // next beat in the input register always sees the updated state.
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (advance) begin
      hist <= hist_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // The filter state changes only when a beat completes its step.
  a_hist_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(hist))
    else $error("history changed without a completed step");

  // A beat that cannot move on stays in the input register unchanged.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_item)))
    else $error("input register lost or altered a waiting beat");

  // A completed step always presents a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("completed step produced no result");

  // A point cannot be both a positive and a negative peak, and the peak value
  // reads zero when neither flag is set.
  a_peak_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!(out_data.pos_peak && out_data.neg_peak) &&
                   ((out_data.pos_peak || out_data.neg_peak) ||
                    (out_data.peak_value == 16'sd0))))
    else $error("inconsistent peak flags or peak value");

endmodule

`default_nettype wire
